// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/glu_pkg.sv
`timescale 1ns / 1ps

package glu_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int LCM_WIDTH         = 63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_step;
    logic mul;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic both_nonzero;
    logic div_last;
  } dp_status_t;

endpackage

// File: rtl/glu_datapath.sv
`timescale 1ns / 1ps

module glu_datapath #(
  parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic [glu_pkg::FIELD_WIDTH-1:0]  first_value,
  input  logic [glu_pkg::FIELD_WIDTH-1:0]  second_value,
  input  glu_pkg::ctrl_cmd_t               cmd,
  output glu_pkg::dp_status_t              status,
  output logic [glu_pkg::FIELD_WIDTH-1:0]  gcd_value,
  output logic [glu_pkg::LCM_WIDTH-1:0]    lcm_value,
  output logic                             lcm_valid
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]   a_mag;
  logic [W-1:0]   b_mag;
  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [W-1:0]   u;
  logic [W-1:0]   v;
  logic [CW-1:0]  k;
  logic [W-1:0]   g;
  logic [W-1:0]   q;
  logic [W-1:0]   r;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] prod;
  logic           valid;
  logic [W:0]     r_shift;
  logic [W:0]     r_diff;
  logic [63:0]    prod_ext;

  // Two's complement magnitude; the most negative value maps to 2^(W-1).
  assign a_mag = first_value[W-1] ? (~first_value[W-1:0] + W'(1)) : first_value[W-1:0];
  assign b_mag = second_value[W-1] ? (~second_value[W-1:0] + W'(1)) : second_value[W-1:0];

  assign r_shift = {r, q[W-1]};
  assign r_diff  = r_shift - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a     <= a_mag;
      b     <= b_mag;
      u     <= a_mag;
      v     <= b_mag;
      k     <= '0;
      valid <= (a_mag != '0) && (b_mag != '0);
      prod  <= '0;
    end else if (cmd.gcd_step) begin
      if (status.gcd_done) begin
        // With one side zero the other holds the gcd with its common factor 2^k removed.
        g   <= (u | v) << k;
        q   <= a;
        r   <= '0;
        cnt <= '0;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + CW'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end else if (cmd.div_step) begin
      // Restoring division: one quotient bit per cycle, shifted in below the dividend.
      if (!r_diff[W]) begin
        r <= r_diff[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= r_shift[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt + CW'(1);
    end else if (cmd.mul) begin
      prod <= {{W{1'b0}}, q} * {{W{1'b0}}, b};
    end
  end

  assign status.gcd_done     = (u == '0) || (v == '0);
  assign status.both_nonzero = valid;
  assign status.div_last     = (cnt == CW'(W - 1));

  assign prod_ext  = 64'(prod);
  assign gcd_value = glu_pkg::FIELD_WIDTH'(g);
  assign lcm_value = prod_ext[glu_pkg::LCM_WIDTH-1:0];
  assign lcm_valid = valid;

endmodule

// File: rtl/glu_controller.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glu_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  glu_pkg::dp_status_t status,
  output glu_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                done
);

  glu_pkg::state_t state;
  glu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    case (state)
      glu_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = glu_pkg::ST_GCD;
        end
      end
      glu_pkg::ST_GCD: begin
        cmd.gcd_step = 1'b1;
        if (status.gcd_done) begin
          state_next = status.both_nonzero ? glu_pkg::ST_DIV : glu_pkg::ST_DONE;
        end
      end
      glu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = glu_pkg::ST_MUL;
        end
      end
      glu_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = glu_pkg::ST_DONE;
      end
      glu_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = glu_pkg::ST_IDLE;
      end
      default: begin
        state_next = glu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != glu_pkg::ST_IDLE);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy)

endmodule

// File: rtl/gcd_lcm_unit_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Greatest common divisor and least common multiple of the magnitudes of two
// signed operands. An operand pair is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must capture it then. A pair with a zero operand
// goes from the gcd state straight to the done state. Otherwise the binary
// gcd loop runs one step a cycle until one side is zero, then the restoring
// divider forms |x|/gcd, the multiply state multiplies by |y| and the done
// state presents the result. Only the low OPERAND_WIDTH bits of each operand
// are used, the top one as the sign.
module gcd_lcm_unit_core #(
  parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] first_value,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] second_value,
  output logic                            done,
  output logic [glu_pkg::FIELD_WIDTH-1:0] gcd_value,
  output logic [glu_pkg::LCM_WIDTH-1:0]   lcm_value,
  output logic                            lcm_valid
);

  glu_pkg::ctrl_cmd_t  cmd;
  glu_pkg::dp_status_t status;

  glu_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  glu_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .first_value  (first_value),
    .second_value (second_value),
    .cmd          (cmd),
    .status       (status),
    .gcd_value    (gcd_value),
    .lcm_value    (lcm_value),
    .lcm_valid    (lcm_valid)
  );

  `ASSERT_IMPL(a_lcm_zero, clk, rst, done && !lcm_valid, lcm_value == '0)
  `ASSERT_IMPL(a_gcd_nonzero, clk, rst, done && lcm_valid, gcd_value != '0 && lcm_value != '0)

endmodule
